### rtl/rdte_pkg.sv
// ----------------------------------------------------------------------------
// rdte_pkg
// Shared types, constants and helpers of the road dyno torque and power
// estimator.
// ----------------------------------------------------------------------------
package rdte_pkg;

   // default window depths
   localparam int RPM_WINDOW_DEF   = 8;
   localparam int POWER_WINDOW_DEF = 8;

   // rpm filter thresholds
   localparam int RPM_SMOOTH_DIFF = 10;
   localparam int RPM_FALL_RESET  = 100;

   // field widths
   localparam int RPM_W      = 15;
   localparam int TIME_W     = 40;
   localparam int THR_W      = 10;
   localparam int AVG_W      = 24;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;

   localparam logic [AVG_W-1:0] MAX24 = '1;

   // shared multiply / divide unit
   localparam int MDU_W         = 64;
   localparam int MDU_DEN_W     = 44;
   localparam int MDU_MUL_STEPS = 24;

   // scale factors of the physics
   localparam logic [MDU_DEN_W-1:0] SPEED_K    = 44'd31416;
   localparam logic [MDU_W-1:0]     SPEED_DEN_K = 64'd600000;
   localparam logic [MDU_DEN_W-1:0] ACCEL_K    = 44'd1000000;
   localparam logic [MDU_DEN_W-1:0] DRAG_DIV   = 44'd1000;
   localparam logic [MDU_DEN_W-1:0] TRQ_DIV    = 44'd2000;
   localparam logic [MDU_W-1:0]     TRQ_DEN_K  = 64'd1000;
   localparam logic [MDU_DEN_W-1:0] HP_K       = 44'd737562;
   localparam logic [MDU_DEN_W-1:0] HP_DIV     = 44'd5252000000;
   localparam logic [MDU_W-1:0]     FORCE_CAP  = 64'd1 << 50;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WHEEL_DIAMETER,
      CSR_GEAR_REDUCTION,
      CSR_VEHICLE_MASS,
      CSR_DRAG_COEFF,
      CSR_RPM_STEP,
      CSR_TPS_MIN,
      CSR_TPS_DROP,
      CSR_MIN_INTERVAL
   } csr_index_type;

   typedef enum logic {
      MDU_MUL,
      MDU_DIV
   } mdu_op_type;

   typedef struct packed {
      logic                 start;
      mdu_op_type           op;
      logic [MDU_W-1:0]     a;
      logic [MDU_DEN_W-1:0] b;
   } mdu_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [MDU_W-1:0] result;
   } mdu_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RPM_MEAN,
      ST_RPM_CHK,
      ST_SPD_MUL1,
      ST_SPD_MUL2,
      ST_SPD_DEN,
      ST_SPD_DIV,
      ST_ACC_MUL1,
      ST_ACC_MUL2,
      ST_ACC_DIV,
      ST_DRG_MUL1,
      ST_DRG_DIV,
      ST_DRG_MUL2,
      ST_TRQ_MUL,
      ST_TRQ_DIV1,
      ST_TRQ_DEN,
      ST_TRQ_DIV2,
      ST_HP_MUL1,
      ST_HP_MUL2,
      ST_HP_DIV,
      ST_PUSH,
      ST_TQ_MEAN,
      ST_PW_MEAN,
      ST_STORE,
      ST_EMIT
   } state_type;

   // clamp to 24 bits
   function automatic logic [AVG_W-1:0] sat24(input logic [MDU_W-1:0] x);
      return (x > MDU_W'(MAX24)) ? MAX24 : x[AVG_W-1:0];
   endfunction

endpackage

### rtl/rdte_if.sv
// ----------------------------------------------------------------------------
// rdte channel interfaces
// Valid / ready channels for engine samples and for results.
// ----------------------------------------------------------------------------
interface rdte_req_if;
   logic                          valid;
   logic                          ready;
   logic [rdte_pkg::RPM_W-1:0]    rpm;
   logic [rdte_pkg::TIME_W-1:0]   time_us;
   logic [rdte_pkg::THR_W-1:0]    throttle;

   modport source (output valid, rpm, time_us, throttle, input ready);
   modport sink   (input valid, rpm, time_us, throttle, output ready);
endinterface

interface rdte_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          point_done;
   logic                          run_reset;
   logic [rdte_pkg::AVG_W-1:0]    torque_avg;
   logic [rdte_pkg::AVG_W-1:0]    power_avg;

   modport source (output valid, point_done, run_reset, torque_avg, power_avg,
                   input ready);
   modport sink   (input valid, point_done, run_reset, torque_avg, power_avg,
                   output ready);
endinterface

### rtl/rdte_mdu.sv
// ----------------------------------------------------------------------------
// rdte_mdu
// Shared serial unit: shift-add multiply (one multiplier bit per cycle) and
// restoring divide (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module rdte_mdu (
   input  logic                  clock,
   input  logic                  reset,
   input  rdte_pkg::mdu_req_type req,
   output rdte_pkg::mdu_rsp_type rsp
);

   localparam int W  = rdte_pkg::MDU_W;
   localparam int DW = rdte_pkg::MDU_DEN_W;
   localparam int CW = $clog2(W);
   localparam logic [CW-1:0] DIV_LAST = CW'(W - 1);
   localparam logic [CW-1:0] MUL_LAST = CW'(rdte_pkg::MDU_MUL_STEPS - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   rdte_pkg::mdu_op_type op_ff, op_in;
   logic [W-1:0]         acc_ff, acc_in;
   logic [W-1:0]         opa_ff, opa_in;
   logic [DW-1:0]        den_ff, den_in;
   logic [DW-1:0]        rem_ff, rem_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [DW:0]          rem_sh;
   logic                 last;

   // one step of multiply or divide
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      rem_sh  = {rem_ff, acc_ff[W-1]};
      last    = (op_ff == rdte_pkg::MDU_MUL) ? (cnt_ff == MUL_LAST) : (cnt_ff == DIV_LAST);
      if (req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         cnt_in  = '0;
         den_in  = req.b;
         rem_in  = '0;
         opa_in  = req.a;
         acc_in  = (req.op == rdte_pkg::MDU_MUL) ? '0 : req.a;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (op_ff == rdte_pkg::MDU_MUL) begin
            if (den_ff[0]) begin
               acc_in = acc_ff + opa_ff;
            end
            opa_in = {opa_ff[W-2:0], 1'b0};
            den_in = {1'b0, den_ff[DW-1:1]};
         end else begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = DW'(rem_sh - {1'b0, den_ff});
               acc_in = {acc_ff[W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DW-1:0];
               acc_in = {acc_ff[W-2:0], 1'b0};
            end
         end
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.busy   = busy_ff;
   assign rsp.done   = done_ff;
   assign rsp.result = acc_ff;

endmodule

### rtl/road_dyno_torque_power_estimator.sv
// Accept to result valid: a sample with rpm zero, a throttle run reset or a skip
// before averaging goes from the check straight to the result; a skip or run
// reset after the rpm average follows its divide; a first point ends after road
// speed; a full point runs every step. Throughput: one sample at a time, the next
// accepted in the cycle after the result is loaded; set by the shared serial unit
// (up to 9 divides a point); a result held in the output register stalls the load.
// Reset: synchronous; clears run state, means and fills, loads register defaults.
// ----------------------------------------------------------------------------
// road_dyno_torque_power_estimator
// Estimates engine torque and horsepower from rpm and time samples, with
// windowed averaging and run reset detection.
// ----------------------------------------------------------------------------
module road_dyno_torque_power_estimator #(
   parameter int RPM_WINDOW   = rdte_pkg::RPM_WINDOW_DEF,
   parameter int POWER_WINDOW = rdte_pkg::POWER_WINDOW_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   rdte_req_if.sink                           req_ch,
   rdte_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [rdte_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rdte_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int RW  = rdte_pkg::RPM_W;
   localparam int TW  = rdte_pkg::TIME_W;
   localparam int HW  = rdte_pkg::THR_W;
   localparam int AW  = rdte_pkg::AVG_W;
   localparam int W   = rdte_pkg::MDU_W;
   localparam int DW  = rdte_pkg::MDU_DEN_W;
   localparam int RFW = $clog2(RPM_WINDOW + 1);
   localparam int PFW = $clog2(POWER_WINDOW + 1);
   localparam int RSW = RW + RFW;
   localparam int PSW = AW + PFW;

   // configuration registers
   logic [10:0] wheel_ff;
   logic [23:0] gear_ff;
   logic [13:0] mass_ff;
   logic [23:0] dragc_ff;
   logic [10:0] rpm_step_ff;
   logic [9:0]  tps_min_ff;
   logic [9:0]  tps_drop_ff;
   logic [23:0] min_int_ff;

   rdte_pkg::state_type state_ff, state_in;

   // sample under work
   logic [RW-1:0] s_rpm_ff, s_rpm_in;
   logic [TW-1:0] s_time_ff, s_time_in;
   logic [HW-1:0] s_thr_ff, s_thr_in;

   // run state
   logic           last_valid_ff, last_valid_in;
   logic [RW-1:0]  lp_rpm_ff, lp_rpm_in;
   logic [TW-1:0]  lp_time_ff, lp_time_in;
   logic [HW-1:0]  lp_thr_ff, lp_thr_in;
   logic [AW-1:0]  lp_speed_ff, lp_speed_in;
   logic [RW-1:0]  last_raw_ff, last_raw_in;
   logic [RFW-1:0] rfill_ff, rfill_in;
   logic [PFW-1:0] pfill_ff, pfill_in;
   logic [RSW-1:0] rsum_ff, rsum_in;
   logic [PSW-1:0] tsum_ff, tsum_in;
   logic [PSW-1:0] psum_ff, psum_in;
   logic [AW-1:0]  tmean_ff, tmean_in;
   logic [AW-1:0]  pmean_ff, pmean_in;

   // histories, shift lines
   logic [RW-1:0] rhist_ff [RPM_WINDOW];
   logic [AW-1:0] thist_ff [POWER_WINDOW];
   logic [AW-1:0] phist_ff [POWER_WINDOW];
   logic          rpush, ppush;

   // work registers
   logic          hasp_ff, hasp_in;
   logic [RW-1:0] prpm_ff, prpm_in;
   logic [AW-1:0] v_ff, v_in;
   logic [W-1:0]  tmp_ff, tmp_in;
   logic [DW-1:0] den_ff, den_in;
   logic [W-1:0]  f_ff, f_in;
   logic [AW-1:0] tq_ff, tq_in;
   logic [AW-1:0] hp_ff, hp_in;
   logic          pd_ff, pd_in;
   logic          rr_ff, rr_in;
   logic          issued_ff, issued_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          o_pd_ff, o_rr_ff;
   logic [AW-1:0] o_tq_ff, o_pw_ff;
   logic          o_load;

   // serial unit
   rdte_pkg::mdu_req_type mdu_req;
   rdte_pkg::mdu_rsp_type mdu_rsp;
   logic                  go;
   logic                  mdu_done;

   // decision helpers
   logic          thr_reset;
   logic          has_prev;
   logic          time_short;
   logic [RW-1:0] rdiff;
   logic [RW-1:0] pdiff;
   logic          rfull, pfull;
   logic [AW-1:0] dv;
   logic [TW-1:0] dt_raw;
   logic [TW-1:0] dt;
   logic [W-1:0]  fsum;
   logic          accept;

   rdte_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .req   (mdu_req),
      .rsp   (mdu_rsp)
   );

   assign accept   = req_ch.valid && req_ch.ready;
   assign mdu_done = issued_ff && mdu_rsp.done;

   always_comb begin
      thr_reset  = (s_thr_ff < tps_min_ff) ||
                   (last_valid_ff && (lp_thr_ff > s_thr_ff) &&
                    ((lp_thr_ff - s_thr_ff) > tps_drop_ff));
      has_prev   = last_valid_ff && (lp_time_ff != '0);
      time_short = (s_time_ff < lp_time_ff) ||
                   ((s_time_ff - lp_time_ff) < TW'(min_int_ff));
      rdiff      = (s_rpm_ff > lp_rpm_ff) ? (s_rpm_ff - lp_rpm_ff) : (lp_rpm_ff - s_rpm_ff);
      pdiff      = (prpm_ff > lp_rpm_ff) ? (prpm_ff - lp_rpm_ff) : (lp_rpm_ff - prpm_ff);
      rfull      = (rfill_ff == RFW'(RPM_WINDOW));
      pfull      = (pfill_ff == PFW'(POWER_WINDOW));
      dv         = (v_ff > lp_speed_ff) ? (v_ff - lp_speed_ff) : '0;
      dt_raw     = s_time_ff - lp_time_ff;
      dt         = (dt_raw == '0) ? TW'(1) : dt_raw;
      fsum       = f_ff + (mdu_rsp.result >> 16);
   end

   // sequencer: next state, datapath updates and unit requests
   always_comb begin
      state_in      = state_ff;
      s_rpm_in      = s_rpm_ff;
      s_time_in     = s_time_ff;
      s_thr_in      = s_thr_ff;
      last_valid_in = last_valid_ff;
      lp_rpm_in     = lp_rpm_ff;
      lp_time_in    = lp_time_ff;
      lp_thr_in     = lp_thr_ff;
      lp_speed_in   = lp_speed_ff;
      last_raw_in   = last_raw_ff;
      rfill_in      = rfill_ff;
      pfill_in      = pfill_ff;
      rsum_in       = rsum_ff;
      tsum_in       = tsum_ff;
      psum_in       = psum_ff;
      tmean_in      = tmean_ff;
      pmean_in      = pmean_ff;
      hasp_in       = hasp_ff;
      prpm_in       = prpm_ff;
      v_in          = v_ff;
      tmp_in        = tmp_ff;
      den_in        = den_ff;
      f_in          = f_ff;
      tq_in         = tq_ff;
      hp_in         = hp_ff;
      pd_in         = pd_ff;
      rr_in         = rr_ff;
      rpush         = 1'b0;
      ppush         = 1'b0;
      o_load        = 1'b0;
      go            = 1'b0;
      mdu_req.op    = rdte_pkg::MDU_MUL;
      mdu_req.a     = '0;
      mdu_req.b     = '0;

      case (state_ff)
         rdte_pkg::ST_IDLE: begin
            if (accept) begin
               s_rpm_in  = req_ch.rpm;
               s_time_in = req_ch.time_us;
               s_thr_in  = req_ch.throttle;
               pd_in     = 1'b0;
               rr_in     = 1'b0;
               state_in  = rdte_pkg::ST_CHECK;
            end
         end
         rdte_pkg::ST_CHECK: begin
            hasp_in  = has_prev;
            state_in = rdte_pkg::ST_EMIT;
            if (s_rpm_ff == '0) begin
               state_in = rdte_pkg::ST_EMIT;
            end else if (thr_reset) begin
               last_valid_in = 1'b0;
               rfill_in      = '0;
               pfill_in      = '0;
               rsum_in       = '0;
               tsum_in       = '0;
               psum_in       = '0;
               tmean_in      = '0;
               pmean_in      = '0;
               rr_in         = 1'b1;
            end else if (has_prev) begin
               if (s_rpm_ff != last_raw_ff) begin
                  last_raw_in = s_rpm_ff;
                  if (!time_short && (rdiff >= RW'(rdte_pkg::RPM_SMOOTH_DIFF))) begin
                     rpush    = 1'b1;
                     rsum_in  = rsum_ff + RSW'(s_rpm_ff) -
                                (rfull ? RSW'(rhist_ff[RPM_WINDOW-1]) : RSW'(0));
                     rfill_in = rfull ? rfill_ff : rfill_ff + 1'b1;
                     state_in = rdte_pkg::ST_RPM_MEAN;
                  end
               end
            end else begin
               prpm_in  = s_rpm_ff;
               state_in = rdte_pkg::ST_SPD_MUL1;
            end
         end
         rdte_pkg::ST_RPM_MEAN: begin
            go         = 1'b1;
            mdu_req.op = rdte_pkg::MDU_DIV;
            mdu_req.a  = W'(rsum_ff);
            mdu_req.b  = DW'(rfill_ff);
            if (mdu_done) begin
               prpm_in  = mdu_rsp.result[RW-1:0];
               state_in = rdte_pkg::ST_RPM_CHK;
            end
         end
         rdte_pkg::ST_RPM_CHK: begin
            if (({1'b0, prpm_ff} + 16'(rdte_pkg::RPM_FALL_RESET)) < {1'b0, lp_rpm_ff}) begin
               last_valid_in = 1'b0;
               rfill_in      = '0;
               pfill_in      = '0;
               rsum_in       = '0;
               tsum_in       = '0;
               psum_in       = '0;
               tmean_in      = '0;
               pmean_in      = '0;
               rr_in         = 1'b1;
               state_in      = rdte_pkg::ST_EMIT;
            end else if (pdiff < RW'(rpm_step_ff)) begin
               state_in = rdte_pkg::ST_EMIT;
            end else begin
               state_in = rdte_pkg::ST_SPD_MUL1;
            end
         end
         // road speed
         rdte_pkg::ST_SPD_MUL1: begin
            if (gear_ff == '0) begin
               v_in     = rdte_pkg::MAX24;
               state_in = hasp_ff ? rdte_pkg::ST_ACC_MUL1 : rdte_pkg::ST_STORE;
            end else begin
               go        = 1'b1;
               mdu_req.a = W'(prpm_ff);
               mdu_req.b = DW'(wheel_ff);
               if (mdu_done) begin
                  tmp_in   = mdu_rsp.result;
                  state_in = rdte_pkg::ST_SPD_MUL2;
               end
            end
         end
         rdte_pkg::ST_SPD_MUL2: begin
            go        = 1'b1;
            mdu_req.a = tmp_ff;
            mdu_req.b = rdte_pkg::SPEED_K;
            if (mdu_done) begin
               tmp_in   = mdu_rsp.result;
               state_in = rdte_pkg::ST_SPD_DEN;
            end
         end
         rdte_pkg::ST_SPD_DEN: begin
            go        = 1'b1;
            mdu_req.a = rdte_pkg::SPEED_DEN_K;
            mdu_req.b = DW'(gear_ff);
            if (mdu_done) begin
               den_in   = mdu_rsp.result[DW-1:0];
               state_in = rdte_pkg::ST_SPD_DIV;
            end
         end
         rdte_pkg::ST_SPD_DIV: begin
            go         = 1'b1;
            mdu_req.op = rdte_pkg::MDU_DIV;
            mdu_req.a  = {tmp_ff[W-17:0], 16'd0};
            mdu_req.b  = den_ff;
            if (mdu_done) begin
               v_in     = rdte_pkg::sat24(mdu_rsp.result);
               state_in = hasp_ff ? rdte_pkg::ST_ACC_MUL1 : rdte_pkg::ST_STORE;
            end
         end
         // acceleration force
         rdte_pkg::ST_ACC_MUL1: begin
            go        = 1'b1;
            mdu_req.a = W'(mass_ff);
            mdu_req.b = DW'(dv);
            if (mdu_done) begin
               tmp_in   = mdu_rsp.result;
               state_in = rdte_pkg::ST_ACC_MUL2;
            end
         end
         rdte_pkg::ST_ACC_MUL2: begin
            go        = 1'b1;
            mdu_req.a = tmp_ff;
            mdu_req.b = rdte_pkg::ACCEL_K;
            if (mdu_done) begin
               tmp_in   = mdu_rsp.result;
               state_in = rdte_pkg::ST_ACC_DIV;
            end
         end
         rdte_pkg::ST_ACC_DIV: begin
            go         = 1'b1;
            mdu_req.op = rdte_pkg::MDU_DIV;
            mdu_req.a  = tmp_ff;
            mdu_req.b  = DW'(dt);
            if (mdu_done) begin
               f_in     = mdu_rsp.result;
               state_in = rdte_pkg::ST_DRG_MUL1;
            end
         end
         // drag force
         rdte_pkg::ST_DRG_MUL1: begin
            go        = 1'b1;
            mdu_req.a = W'(v_ff);
            mdu_req.b = DW'(v_ff);
            if (mdu_done) begin
               tmp_in   = mdu_rsp.result;
               state_in = rdte_pkg::ST_DRG_DIV;
            end
         end
         rdte_pkg::ST_DRG_DIV: begin
            go         = 1'b1;
            mdu_req.op = rdte_pkg::MDU_DIV;
            mdu_req.a  = tmp_ff;
            mdu_req.b  = rdte_pkg::DRAG_DIV;
            if (mdu_done) begin
               tmp_in   = mdu_rsp.result;
               state_in = rdte_pkg::ST_DRG_MUL2;
            end
         end
         rdte_pkg::ST_DRG_MUL2: begin
            go        = 1'b1;
            mdu_req.a = tmp_ff;
            mdu_req.b = DW'(dragc_ff);
            if (mdu_done) begin
               f_in     = (fsum > rdte_pkg::FORCE_CAP) ? rdte_pkg::FORCE_CAP : fsum;
               state_in = rdte_pkg::ST_TRQ_MUL;
            end
         end
         // engine torque
         rdte_pkg::ST_TRQ_MUL: begin
            if (gear_ff == '0) begin
               tq_in    = rdte_pkg::MAX24;
               state_in = rdte_pkg::ST_HP_MUL1;
            end else begin
               go        = 1'b1;
               mdu_req.a = f_ff;
               mdu_req.b = DW'(wheel_ff);
               if (mdu_done) begin
                  tmp_in   = mdu_rsp.result;
                  state_in = rdte_pkg::ST_TRQ_DIV1;
               end
            end
         end
         rdte_pkg::ST_TRQ_DIV1: begin
            go         = 1'b1;
            mdu_req.op = rdte_pkg::MDU_DIV;
            mdu_req.a  = tmp_ff;
            mdu_req.b  = rdte_pkg::TRQ_DIV;
            if (mdu_done) begin
               tmp_in   = mdu_rsp.result;
               state_in = rdte_pkg::ST_TRQ_DEN;
            end
         end
         rdte_pkg::ST_TRQ_DEN: begin
            go        = 1'b1;
            mdu_req.a = rdte_pkg::TRQ_DEN_K;
            mdu_req.b = DW'(gear_ff);
            if (mdu_done) begin
               den_in   = mdu_rsp.result[DW-1:0];
               state_in = rdte_pkg::ST_TRQ_DIV2;
            end
         end
         rdte_pkg::ST_TRQ_DIV2: begin
            if (tmp_ff >= W'(den_ff)) begin
               tq_in    = rdte_pkg::MAX24;
               state_in = rdte_pkg::ST_HP_MUL1;
            end else begin
               go         = 1'b1;
               mdu_req.op = rdte_pkg::MDU_DIV;
               mdu_req.a  = {tmp_ff[W-25:0], 24'd0};
               mdu_req.b  = den_ff;
               if (mdu_done) begin
                  tq_in    = rdte_pkg::sat24(mdu_rsp.result);
                  state_in = rdte_pkg::ST_HP_MUL1;
               end
            end
         end
         // horsepower
         rdte_pkg::ST_HP_MUL1: begin
            go        = 1'b1;
            mdu_req.a = W'(tq_ff);
            mdu_req.b = DW'(prpm_ff);
            if (mdu_done) begin
               tmp_in   = mdu_rsp.result;
               state_in = rdte_pkg::ST_HP_MUL2;
            end
         end
         rdte_pkg::ST_HP_MUL2: begin
            go        = 1'b1;
            mdu_req.a = tmp_ff;
            mdu_req.b = rdte_pkg::HP_K;
            if (mdu_done) begin
               tmp_in   = mdu_rsp.result;
               state_in = rdte_pkg::ST_HP_DIV;
            end
         end
         rdte_pkg::ST_HP_DIV: begin
            go         = 1'b1;
            mdu_req.op = rdte_pkg::MDU_DIV;
            mdu_req.a  = tmp_ff;
            mdu_req.b  = rdte_pkg::HP_DIV;
            if (mdu_done) begin
               hp_in    = rdte_pkg::sat24(mdu_rsp.result);
               state_in = rdte_pkg::ST_PUSH;
            end
         end
         // window update and means
         rdte_pkg::ST_PUSH: begin
            ppush    = 1'b1;
            tsum_in  = tsum_ff + PSW'(tq_ff) -
                       (pfull ? PSW'(thist_ff[POWER_WINDOW-1]) : PSW'(0));
            psum_in  = psum_ff + PSW'(hp_ff) -
                       (pfull ? PSW'(phist_ff[POWER_WINDOW-1]) : PSW'(0));
            pfill_in = pfull ? pfill_ff : pfill_ff + 1'b1;
            state_in = rdte_pkg::ST_TQ_MEAN;
         end
         rdte_pkg::ST_TQ_MEAN: begin
            go         = 1'b1;
            mdu_req.op = rdte_pkg::MDU_DIV;
            mdu_req.a  = W'(tsum_ff);
            mdu_req.b  = DW'(pfill_ff);
            if (mdu_done) begin
               tmean_in = mdu_rsp.result[AW-1:0];
               state_in = rdte_pkg::ST_PW_MEAN;
            end
         end
         rdte_pkg::ST_PW_MEAN: begin
            go         = 1'b1;
            mdu_req.op = rdte_pkg::MDU_DIV;
            mdu_req.a  = W'(psum_ff);
            mdu_req.b  = DW'(pfill_ff);
            if (mdu_done) begin
               pmean_in = mdu_rsp.result[AW-1:0];
               pd_in    = 1'b1;
               state_in = rdte_pkg::ST_STORE;
            end
         end
         rdte_pkg::ST_STORE: begin
            lp_rpm_in     = prpm_ff;
            lp_time_in    = s_time_ff;
            lp_thr_in     = s_thr_ff;
            lp_speed_in   = v_ff;
            last_valid_in = 1'b1;
            state_in      = rdte_pkg::ST_EMIT;
         end
         rdte_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               o_load   = 1'b1;
               state_in = rdte_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rdte_pkg::ST_IDLE;
         end
      endcase

      mdu_req.start = go && !issued_ff;
      issued_in     = go && !mdu_done;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (o_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and run state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rdte_pkg::ST_IDLE;
         issued_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         last_valid_ff <= 1'b0;
         lp_rpm_ff     <= '0;
         lp_time_ff    <= '0;
         lp_thr_ff     <= '0;
         lp_speed_ff   <= '0;
         last_raw_ff   <= '0;
         rfill_ff      <= '0;
         pfill_ff      <= '0;
         rsum_ff       <= '0;
         tsum_ff       <= '0;
         psum_ff       <= '0;
         tmean_ff      <= '0;
         pmean_ff      <= '0;
         wheel_ff      <= 11'd600;
         gear_ff       <= 24'd262144;
         mass_ff       <= 14'd1200;
         dragc_ff      <= 24'd26214;
         rpm_step_ff   <= 11'd100;
         tps_min_ff    <= 10'd800;
         tps_drop_ff   <= 10'd100;
         min_int_ff    <= 24'd100000;
      end else begin
         state_ff      <= state_in;
         issued_ff     <= issued_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_valid_ff <= last_valid_in;
         lp_rpm_ff     <= lp_rpm_in;
         lp_time_ff    <= lp_time_in;
         lp_thr_ff     <= lp_thr_in;
         lp_speed_ff   <= lp_speed_in;
         last_raw_ff   <= last_raw_in;
         rfill_ff      <= rfill_in;
         pfill_ff      <= pfill_in;
         rsum_ff       <= rsum_in;
         tsum_ff       <= tsum_in;
         psum_ff       <= psum_in;
         tmean_ff      <= tmean_in;
         pmean_ff      <= pmean_in;
         // configuration writes
         if (csr_we) begin
            case (rdte_pkg::csr_index_type'(csr_index))
               rdte_pkg::CSR_WHEEL_DIAMETER: wheel_ff    <= csr_wdata[10:0];
               rdte_pkg::CSR_GEAR_REDUCTION: gear_ff     <= csr_wdata[23:0];
               rdte_pkg::CSR_VEHICLE_MASS:   mass_ff     <= csr_wdata[13:0];
               rdte_pkg::CSR_DRAG_COEFF:     dragc_ff    <= csr_wdata[23:0];
               rdte_pkg::CSR_RPM_STEP:       rpm_step_ff <= csr_wdata[10:0];
               rdte_pkg::CSR_TPS_MIN:        tps_min_ff  <= csr_wdata[9:0];
               rdte_pkg::CSR_TPS_DROP:       tps_drop_ff <= csr_wdata[9:0];
               rdte_pkg::CSR_MIN_INTERVAL:   min_int_ff  <= csr_wdata[23:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload and work registers
   always_ff @(posedge clock) begin
      s_rpm_ff  <= s_rpm_in;
      s_time_ff <= s_time_in;
      s_thr_ff  <= s_thr_in;
      hasp_ff   <= hasp_in;
      prpm_ff   <= prpm_in;
      v_ff      <= v_in;
      tmp_ff    <= tmp_in;
      den_ff    <= den_in;
      f_ff      <= f_in;
      tq_ff     <= tq_in;
      hp_ff     <= hp_in;
      pd_ff     <= pd_in;
      rr_ff     <= rr_in;
      if (o_load) begin
         o_pd_ff <= pd_ff;
         o_rr_ff <= rr_ff;
         o_tq_ff <= tmean_ff;
         o_pw_ff <= pmean_ff;
      end
      if (rpush) begin
         rhist_ff[0] <= s_rpm_ff;
         for (int i = 1; i < RPM_WINDOW; i++) begin
            rhist_ff[i] <= rhist_ff[i-1];
         end
      end
      if (ppush) begin
         thist_ff[0] <= tq_ff;
         phist_ff[0] <= hp_ff;
         for (int i = 1; i < POWER_WINDOW; i++) begin
            thist_ff[i] <= thist_ff[i-1];
            phist_ff[i] <= phist_ff[i-1];
         end
      end
   end

   // channel ports
   assign req_ch.ready      = (state_ff == rdte_pkg::ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.point_done = o_pd_ff;
   assign rsp_ch.run_reset  = o_rr_ff;
   assign rsp_ch.torque_avg = o_tq_ff;
   assign rsp_ch.power_avg  = o_pw_ff;

   // serial unit is free whenever a new sample may enter
   a_mdu_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rdte_pkg::ST_IDLE) |-> !mdu_rsp.busy)
      else $error("serial unit busy while idle");

   // rpm window never overfills
   a_rfill_bound: assert property (@(posedge clock) disable iff (reset)
      rfill_ff <= RFW'(RPM_WINDOW))
      else $error("rpm fill beyond window");

   // empty power window means zero averages
   a_mean_empty: assert property (@(posedge clock) disable iff (reset)
      (pfill_ff == '0) |-> ((tmean_ff == '0) && (pmean_ff == '0)))
      else $error("nonzero mean with empty window");

   // a transaction never flags both a point and a run reset
   a_pd_rr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(o_pd_ff && o_rr_ff))
      else $error("point and run reset together");

endmodule
